[hw/rtl/tpoc_pkg.sv]
// Shared types and constants of the thermostat PI / on-off controller.
package tpoc_pkg;

  localparam int ZONES_DEFAULT = 4;
  localparam int ZONE_W        = 2;
  localparam int TEMP_W        = 16;
  localparam int BAND_W        = 15;
  localparam int GAIN_W        = 16;
  localparam int DRIVE_W       = 16;
  localparam int PROD_W        = 34;
  localparam int ACC_W         = 36;
  localparam int FIFO_DEPTH    = 2;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = {DRIVE_W{1'b1}};
  localparam logic signed [TEMP_W-1:0] FLOOR_RESET = {1'b1, {(TEMP_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_FAULT = 2'd0,
    OP_LEVEL = 2'd1,
    OP_PI    = 2'd2
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [ZONE_W-1:0]        zone;
    logic                     level;
    logic                     err_pos;
    logic                     err_neg;
    logic signed [PROD_W-1:0] p_term;
    logic signed [PROD_W-1:0] i_prod;
  } job_t;

endpackage

[hw/rtl/thermostat_pi_onoff_controller.sv]
// Top level of the multi-zone thermostat controller (PI with anti-windup or on/off).
// One request is taken every clock cycle as long as the two-entry job queue has room;
// a result passes through the queue register, then the result register, before it appears.
// The per-zone integrator is read, updated and written in the same back-end cycle, so
// consecutive PI ticks on the same zone follow each other at full rate. Requests that
// give no result (override, mode mismatch, zone out of range, an on/off reading inside the
// band with no sensor fault) are dropped at the front. The sensor floor register resets to
// -32768 and is always ready to be written.
module thermostat_pi_onoff_controller #(
  parameter int Zones = tpoc_pkg::ZONES_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic signed [tpoc_pkg::TEMP_W-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [tpoc_pkg::ZONE_W-1:0]         zone_i,
  input  logic signed [tpoc_pkg::TEMP_W-1:0]  measured_temp_i,
  input  logic signed [tpoc_pkg::TEMP_W-1:0]  target_temp_i,
  input  logic                                ctl_mode_i,
  input  logic [tpoc_pkg::BAND_W-1:0]         band_i,
  input  logic [tpoc_pkg::GAIN_W-1:0]         prop_gain_i,
  input  logic [tpoc_pkg::GAIN_W-1:0]         integ_gain_i,
  input  logic                                overridden_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tpoc_pkg::ZONE_W-1:0]         out_zone_o,
  output logic [tpoc_pkg::DRIVE_W-1:0]        drive_level_o,
  output logic                                sensor_fault_o
);
  import tpoc_pkg::*;

  logic push;
  logic pop;
  logic empty;
  logic full;
  job_t push_job;
  job_t pop_job;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  tpoc_front #(.Zones(Zones)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .cmd_i           (cmd_i),
    .zone_i          (zone_i),
    .measured_temp_i (measured_temp_i),
    .target_temp_i   (target_temp_i),
    .ctl_mode_i      (ctl_mode_i),
    .band_i          (band_i),
    .prop_gain_i     (prop_gain_i),
    .integ_gain_i    (integ_gain_i),
    .overridden_i    (overridden_i),
    .accept_i        (!full),
    .push_o          (push),
    .job_o           (push_job)
  );

  tpoc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty),
    .full_o      (full)
  );

  tpoc_back #(.Zones(Zones)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (!empty),
    .job_i          (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_zone_o     (out_zone_o),
    .drive_level_o  (drive_level_o),
    .sensor_fault_o (sensor_fault_o)
  );

endmodule

[hw/rtl/tpoc_front.sv]
// Front end: takes requests, filters and classifies them, forms the PI products.
module tpoc_front #(
  parameter int Zones = tpoc_pkg::ZONES_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic signed [tpoc_pkg::TEMP_W-1:0]     cfg_data_i,
  input  logic                                   in_valid_i,
  input  logic                                   cmd_i,
  input  logic [tpoc_pkg::ZONE_W-1:0]            zone_i,
  input  logic signed [tpoc_pkg::TEMP_W-1:0]     measured_temp_i,
  input  logic signed [tpoc_pkg::TEMP_W-1:0]     target_temp_i,
  input  logic                                   ctl_mode_i,
  input  logic [tpoc_pkg::BAND_W-1:0]            band_i,
  input  logic [tpoc_pkg::GAIN_W-1:0]            prop_gain_i,
  input  logic [tpoc_pkg::GAIN_W-1:0]            integ_gain_i,
  input  logic                                   overridden_i,
  input  logic                                   accept_i,
  output logic                                   push_o,
  output tpoc_pkg::job_t                         job_o
);
  import tpoc_pkg::*;

  logic signed [TEMP_W-1:0] floor_q;
  logic signed [TEMP_W-1:0] floor_d;
  logic [7:0]               zone_ext;
  logic                     zone_ok;
  logic                     fault;
  logic signed [TEMP_W:0]   err;
  logic signed [TEMP_W+1:0] meas_x;
  logic signed [TEMP_W+1:0] hi_lim;
  logic signed [TEMP_W+1:0] lo_lim;
  logic                     above;
  logic                     below;

  assign floor_d = cfg_valid_i ? cfg_data_i : floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_RESET;
    end else begin
      floor_q <= floor_d;
    end
  end

  assign zone_ext = {{(8-ZONE_W){1'b0}}, zone_i};
  assign zone_ok  = zone_ext < 8'(Zones);
  assign fault    = measured_temp_i < floor_q;
  assign err      = {target_temp_i[TEMP_W-1], target_temp_i}
                  - {measured_temp_i[TEMP_W-1], measured_temp_i};
  assign meas_x   = {{2{measured_temp_i[TEMP_W-1]}}, measured_temp_i};
  assign hi_lim   = {{2{target_temp_i[TEMP_W-1]}}, target_temp_i}
                  + $signed({3'b000, band_i});
  assign lo_lim   = {{2{target_temp_i[TEMP_W-1]}}, target_temp_i}
                  - $signed({3'b000, band_i});
  assign above    = meas_x > hi_lim;
  assign below    = meas_x < lo_lim;

  always_comb begin
    job_o.zone    = zone_i;
    job_o.level   = below;
    job_o.err_pos = !err[TEMP_W] && (err != '0);
    job_o.err_neg = err[TEMP_W];
    job_o.p_term  = err * $signed({1'b0, prop_gain_i});
    job_o.i_prod  = err * $signed({1'b0, integ_gain_i});
    if (fault) begin
      job_o.op = OP_FAULT;
    end else if (ctl_mode_i) begin
      job_o.op = OP_PI;
    end else begin
      job_o.op = OP_LEVEL;
    end
  end

  assign push_o = in_valid_i && accept_i && zone_ok && !overridden_i
                && (cmd_i == ctl_mode_i)
                && (fault || ctl_mode_i || above || below);

endmodule

[hw/rtl/tpoc_fifo.sv]
// Short job queue between the front and back ends.
module tpoc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tpoc_pkg::job_t push_data_i,
  input  logic           pop_i,
  output tpoc_pkg::job_t pop_data_o,
  output logic           empty_o,
  output logic           full_o
);
  import tpoc_pkg::*;

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W-1:0] rd_ptr_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             do_pop;

  assign empty_o    = count_q == '0;
  assign full_o     = count_q == CNT_W'(FIFO_DEPTH);
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/tpoc_back.sv]
// Back end: integrator update with anti-windup, drive clamp and result register.
module tpoc_back #(
  parameter int Zones = tpoc_pkg::ZONES_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  input  tpoc_pkg::job_t                 job_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tpoc_pkg::ZONE_W-1:0]    out_zone_o,
  output logic [tpoc_pkg::DRIVE_W-1:0]   drive_level_o,
  output logic                           sensor_fault_o
);
  import tpoc_pkg::*;

  localparam int IDX_W = (Zones > 1) ? $clog2(Zones) : 1;

  logic [DRIVE_W-1:0]      integ_q [Zones];
  logic                    out_valid_q;
  logic                    out_valid_d;
  logic [ZONE_W-1:0]       zone_q;
  logic [DRIVE_W-1:0]      drive_q;
  logic [DRIVE_W-1:0]      drive_d;
  logic                    fault_q;
  logic [7:0]              zone_ext;
  logic [IDX_W-1:0]        idx;
  logic signed [ACC_W-1:0] prev;
  logic signed [ACC_W-1:0] p_x;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] cap;
  logic signed [ACC_W-1:0] wind;
  logic [DRIVE_W-1:0]      next_integ;
  logic signed [ACC_W-1:0] drive_x;
  logic                    pi_upd;

  assign zone_ext = {{(8-ZONE_W){1'b0}}, job_i.zone};
  assign idx      = zone_ext[IDX_W-1:0];
  assign pop_o    = job_valid_i && (!out_valid_q || !out_stall_i);
  assign pi_upd   = pop_o && (job_i.op == OP_PI);

  assign prev = $signed({{(ACC_W-DRIVE_W){1'b0}}, integ_q[idx]});
  assign p_x  = ACC_W'(job_i.p_term);
  assign sum  = prev + ACC_W'(job_i.i_prod);
  assign cap  = $signed({{(ACC_W-DRIVE_W){1'b0}}, DRIVE_MAX}) - p_x;

  always_comb begin
    wind = sum;
    if (job_i.err_pos) begin
      if (sum > cap) begin
        wind = (prev < cap) ? cap : prev;
      end
    end else if (job_i.err_neg) begin
      if (sum < 0) begin
        wind = '0;
      end
    end
    if (wind < 0) begin
      next_integ = '0;
    end else if (wind > $signed({{(ACC_W-DRIVE_W){1'b0}}, DRIVE_MAX})) begin
      next_integ = DRIVE_MAX;
    end else begin
      next_integ = wind[DRIVE_W-1:0];
    end
  end

  assign drive_x = p_x + $signed({{(ACC_W-DRIVE_W){1'b0}}, next_integ});

  always_comb begin
    case (job_i.op)
      OP_FAULT: drive_d = '0;
      OP_LEVEL: drive_d = {{(DRIVE_W-1){1'b0}}, job_i.level};
      OP_PI: begin
        if (drive_x < 0) begin
          drive_d = '0;
        end else if (drive_x > $signed({{(ACC_W-DRIVE_W){1'b0}}, DRIVE_MAX})) begin
          drive_d = DRIVE_MAX;
        end else begin
          drive_d = drive_x[DRIVE_W-1:0];
        end
      end
      default: drive_d = '0;
    endcase
  end

  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < Zones; k++) begin
        integ_q[k] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (pi_upd) begin
        integ_q[idx] <= next_integ;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      zone_q  <= job_i.zone;
      drive_q <= drive_d;
      fault_q <= job_i.op == OP_FAULT;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_zone_o     = zone_q;
  assign drive_level_o  = drive_q;
  assign sensor_fault_o = fault_q;

endmodule

[hw/rtl/tpoc_checker.sv]
// Port-level assertions for the thermostat controller, bound to the top level.
module tpoc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [tpoc_pkg::ZONE_W-1:0]         out_zone_o,
  input logic [tpoc_pkg::DRIVE_W-1:0]        drive_level_o,
  input logic                                sensor_fault_o
);
  import tpoc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_zone_o)
      && $stable(drive_level_o) && $stable(sensor_fault_o))
    else $error("stalled result changed");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_fault_o |-> drive_level_o == '0)
    else $error("sensor fault with nonzero drive");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted request");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind thermostat_pi_onoff_controller tpoc_checker u_tpoc_checker (.*);

[tb/tb.sv]
// Self-checking testbench of the thermostat controller: directed, random and stall traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpoc_pkg::*;

  localparam logic CMD_EVENT  = 1'b0;
  localparam logic CMD_TICK   = 1'b1;
  localparam logic MODE_ONOFF = 1'b0;
  localparam logic MODE_PI    = 1'b1;
  localparam int   LIMIT_CYCLES = 200000;
  localparam int   SETTLE_CYCLES = 8;

  typedef struct packed {
    logic               cmd;
    logic [ZONE_W-1:0]  zone;
    logic [TEMP_W-1:0]  meas;
    logic [TEMP_W-1:0]  targ;
    logic               mode;
    logic [BAND_W-1:0]  band;
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic               ovr;
  } ctl_req_t;

  typedef struct packed {
    logic [ZONE_W-1:0]  zone;
    logic [DRIVE_W-1:0] level;
    logic               fault;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic signed [TEMP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic cmd = 1'b0;
  logic [ZONE_W-1:0] zone = '0;
  logic signed [TEMP_W-1:0] measured_temp = '0;
  logic signed [TEMP_W-1:0] target_temp = '0;
  logic ctl_mode = 1'b0;
  logic [BAND_W-1:0] band = '0;
  logic [GAIN_W-1:0] prop_gain = '0;
  logic [GAIN_W-1:0] integ_gain = '0;
  logic overridden = 1'b0;
  logic out_stall = 1'b0;

  logic cfg_ready_o;
  logic in_stall_o;
  logic out_valid_o;
  logic [ZONE_W-1:0] out_zone_o;
  logic [DRIVE_W-1:0] drive_level_o;
  logic sensor_fault_o;

  drive_t drive_q[$];
  logic [DRIVE_W-1:0] zone_integ[0:3] = '{default: '0};
  logic signed [TEMP_W-1:0] sensor_floor = FLOOR_RESET;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int err_count = 0;
  int cycle_count = 0;

  thermostat_pi_onoff_controller uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd),
    .zone_i         (zone),
    .measured_temp_i(measured_temp),
    .target_temp_i  (target_temp),
    .ctl_mode_i     (ctl_mode),
    .band_i         (band),
    .prop_gain_i    (prop_gain),
    .integ_gain_i   (integ_gain),
    .overridden_i   (overridden),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .out_zone_o     (out_zone_o),
    .drive_level_o  (drive_level_o),
    .sensor_fault_o (sensor_fault_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[thermostat_pi_onoff_controller] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    drive_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (drive_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result for zone %0d", out_zone_o));
      end else begin
        want = drive_q.pop_front();
        if (out_zone_o !== want.zone)
          report_mismatch($sformatf("out_zone got %0d want %0d", out_zone_o, want.zone));
        if (drive_level_o !== want.level)
          report_mismatch($sformatf("drive_level got %0d want %0d", drive_level_o,
                                    want.level));
        if (sensor_fault_o !== want.fault)
          report_mismatch($sformatf("sensor_fault got %0b want %0b", sensor_fault_o,
                                    want.fault));
      end
    end
  end

  function automatic bit predict_drive(input ctl_req_t r, output drive_t d);
    longint m, t, b, err, pterm, prev, nxt, cap, lvl, dmax;
    d.zone = r.zone;
    d.level = '0;
    d.fault = 1'b0;
    m = longint'($signed(r.meas));
    t = longint'($signed(r.targ));
    b = longint'(r.band);
    dmax = longint'(DRIVE_MAX);
    if (r.ovr || r.cmd != r.mode) return 1'b0;
    if (m < longint'(sensor_floor)) begin
      d.fault = 1'b1;
      return 1'b1;
    end
    if (r.mode == MODE_PI) begin
      err = t - m;
      pterm = err * longint'(r.kp);
      prev = longint'(zone_integ[r.zone]);
      nxt = prev + err * longint'(r.ki);
      if (err > 0) begin
        cap = dmax - pterm;
        if (nxt > cap) nxt = (prev < cap) ? cap : prev;
      end else if (err < 0 && nxt < 0) begin
        nxt = 0;
      end
      if (nxt < 0) nxt = 0;
      if (nxt > dmax) nxt = dmax;
      zone_integ[r.zone] = nxt[DRIVE_W-1:0];
      lvl = pterm + nxt;
      if (lvl < 0) lvl = 0;
      if (lvl > dmax) lvl = dmax;
      d.level = lvl[DRIVE_W-1:0];
    end else if (m > t + b) begin
      d.level = '0;
    end else if (m < t - b) begin
      d.level = DRIVE_W'(1);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ctl_req_t ctl_req(input logic c, input int z, input int m, input int t,
                                       input logic md, input int b, input int kp, input int ki,
                                       input logic ov);
    ctl_req_t r;
    r.cmd = c;
    r.zone = z[ZONE_W-1:0];
    r.meas = m[TEMP_W-1:0];
    r.targ = t[TEMP_W-1:0];
    r.mode = md;
    r.band = b[BAND_W-1:0];
    r.kp = kp[GAIN_W-1:0];
    r.ki = ki[GAIN_W-1:0];
    r.ovr = ov;
    return r;
  endfunction

  function automatic ctl_req_t rand_req();
    ctl_req_t r;
    int t;
    r.zone = ZONE_W'($urandom_range(0, 3));
    r.mode = 1'($urandom_range(0, 1));
    r.cmd = ($urandom_range(0, 99) < 88) ? r.mode : ~r.mode;
    r.ovr = ($urandom_range(0, 99) < 8);
    if ($urandom_range(0, 3) == 0) begin
      r.targ = TEMP_W'($urandom_range(0, 65535));
      r.meas = TEMP_W'($urandom_range(0, 65535));
    end else begin
      t = int'($urandom_range(0, 6000)) - 3000;
      r.targ = t[TEMP_W-1:0];
      t = t + int'($urandom_range(0, 400)) - 200;
      r.meas = t[TEMP_W-1:0];
    end
    r.band = ($urandom_range(0, 3) == 0) ? BAND_W'($urandom_range(0, 32767))
                                         : BAND_W'($urandom_range(0, 60));
    case ($urandom_range(0, 3))
      0: r.kp = GAIN_W'($urandom_range(0, 65535));
      1: r.kp = '0;
      default: r.kp = GAIN_W'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 3))
      0: r.ki = GAIN_W'($urandom_range(0, 65535));
      1: r.ki = '0;
      default: r.ki = GAIN_W'($urandom_range(0, 40));
    endcase
    return r;
  endfunction

  task automatic send_request(input ctl_req_t r);
    drive_t d;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= r.cmd;
    zone <= r.zone;
    measured_temp <= r.meas;
    target_temp <= r.targ;
    ctl_mode <= r.mode;
    band <= r.band;
    prop_gain <= r.kp;
    integ_gain <= r.ki;
    overridden <= r.ovr;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_drive(r, d)) drive_q.push_back(d);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_floor(input logic signed [TEMP_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sensor_floor = v;
  endtask

  task automatic test_onoff_band();
    send_request(ctl_req(CMD_EVENT, 0, 100, 0, MODE_ONOFF, 10, 0, 0, 1'b0));
    send_request(ctl_req(CMD_EVENT, 1, -100, 0, MODE_ONOFF, 10, 0, 0, 1'b0));
    send_request(ctl_req(CMD_EVENT, 2, 5, 0, MODE_ONOFF, 10, 0, 0, 1'b0));
    send_request(ctl_req(CMD_EVENT, 3, 10, 0, MODE_ONOFF, 10, 0, 0, 1'b0));
    send_request(ctl_req(CMD_EVENT, 0, 32767, -32768, MODE_ONOFF, 32767, 0, 0, 1'b0));
    send_request(ctl_req(CMD_EVENT, 1, -32768, 32767, MODE_ONOFF, 32767, 0, 0, 1'b0));
    send_request(ctl_req(CMD_EVENT, 2, 7, 7, MODE_ONOFF, 0, 0, 0, 1'b0));
    send_request(ctl_req(CMD_EVENT, 3, 100, 0, MODE_ONOFF, 0, 0, 0, 1'b1));
    send_request(ctl_req(CMD_TICK, 0, 100, 0, MODE_ONOFF, 0, 65535, 65535, 1'b0));
  endtask

  task automatic test_pi_windup();
    send_request(ctl_req(CMD_TICK, 1, -32768, 32767, MODE_PI, 0, 65535, 65535, 1'b0));
    send_request(ctl_req(CMD_TICK, 1, 32767, -32768, MODE_PI, 0, 65535, 65535, 1'b0));
    send_request(ctl_req(CMD_TICK, 2, 0, 10, MODE_PI, 0, 1, 1000, 1'b0));
    send_request(ctl_req(CMD_TICK, 2, 0, 10, MODE_PI, 0, 1, 10000, 1'b0));
    send_request(ctl_req(CMD_TICK, 2, 20, 20, MODE_PI, 0, 9, 9, 1'b0));
    send_request(ctl_req(CMD_TICK, 2, 21, 20, MODE_PI, 0, 1, 1, 1'b0));
    send_request(ctl_req(CMD_EVENT, 2, 0, 500, MODE_PI, 0, 3, 3, 1'b0));
    send_request(ctl_req(CMD_TICK, 2, 0, 500, MODE_PI, 0, 3, 3, 1'b1));
  endtask

  task automatic test_sensor_floor();
    write_floor(16'sd0);
    send_request(ctl_req(CMD_TICK, 3, -1, 100, MODE_PI, 0, 5, 5, 1'b0));
    send_request(ctl_req(CMD_EVENT, 0, -1, 100, MODE_ONOFF, 3, 0, 0, 1'b0));
    send_request(ctl_req(CMD_TICK, 1, -500, 100, MODE_PI, 0, 5, 5, 1'b1));
    send_request(ctl_req(CMD_EVENT, 1, -500, 100, MODE_PI, 0, 5, 5, 1'b0));
    write_floor(16'sh7fff);
    send_request(ctl_req(CMD_EVENT, 2, 32767, 0, MODE_ONOFF, 0, 0, 0, 1'b0));
    send_request(ctl_req(CMD_TICK, 2, 32766, 0, MODE_PI, 0, 0, 0, 1'b0));
    write_floor(FLOOR_RESET);
  endtask

  task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_request(rand_req());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 120;
    for (int k = 0; k < 30; k++)
      send_request(ctl_req(CMD_TICK, k % 4, 0, k * 3 - 40, MODE_PI, 0, k, 2, 1'b0));
  endtask

  initial begin
    logic signed [TEMP_W-1:0] fv;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_onoff_band();
    test_pi_windup();
    test_sensor_floor();
    write_floor(-16'sd20000);
    test_random_traffic(280, 28, 74);
    fv = TEMP_W'($urandom_range(0, 65535));
    write_floor(fv);
    test_random_traffic(280, 74, 28);
    write_floor(FLOOR_RESET);
    test_random_traffic(280, 0, 0);
    test_backpressure();
    wait_idle();
    if (err_count == 0) begin
      $display("[thermostat_pi_onoff_controller] OK");
    end else begin
      $display("[thermostat_pi_onoff_controller] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tpoc_pkg.sv
hw/rtl/tpoc_front.sv
hw/rtl/tpoc_fifo.sv
hw/rtl/tpoc_back.sv
hw/rtl/thermostat_pi_onoff_controller.sv
hw/rtl/tpoc_checker.sv
tb/tb.sv
